>>> hdl/oaids_pkg.sv
package oaids_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_DELETE  = 2'd1,
    FUNC_SEARCH  = 2'd2,
    FUNC_DISPLAY = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_USE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    wr_shift;
    logic    wr_item;
    logic    step;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    status_e emit_status;
    logic    emit_found;
    logic    emit_data;
    logic    emit_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_e func;
    logic  full;
    logic  bad_pos;
    logic  more;
    logic  match;
    logic  is_last;
    logic  empty;
  } dp_sts_t;

endpackage

>>> hdl/oaids_ram.sv
module oaids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/oaids_dp.sv
module oaids_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [oaids_pkg::FUNC_W-1:0]         func_i,
  input  logic [oaids_pkg::POS_W-1:0]          position_i,
  input  logic signed [oaids_pkg::WORD_W-1:0]  item_i,
  input  oaids_pkg::dp_cmd_t                   cmd_i,
  output oaids_pkg::dp_sts_t                   sts_o,
  output logic                                 result_valid_o,
  output logic [oaids_pkg::STATUS_W-1:0]       status_o,
  output logic [oaids_pkg::IDX_W-1:0]          found_index_o,
  output logic signed [oaids_pkg::WORD_W-1:0]  value_o,
  output logic                                 last_o,
  output logic [oaids_pkg::CNT_W-1:0]          entry_total_o
);

  oaids_pkg::func_e                 func_q;
  logic [oaids_pkg::POS_W-1:0]      pos_q;
  logic [oaids_pkg::WORD_W-1:0]     item_q;
  logic [oaids_pkg::CNT_W-1:0]      j_q, j_d;
  logic [oaids_pkg::CNT_W-1:0]      count_q, count_d;
  logic [oaids_pkg::CNT_W:0]        j_inc;

  logic                             we;
  logic [oaids_pkg::ADDR_W-1:0]     waddr, raddr;
  logic [oaids_pkg::WORD_W-1:0]     wdata, rdata;

  logic                             valid_q;
  logic [oaids_pkg::STATUS_W-1:0]   status_q;
  logic [oaids_pkg::IDX_W-1:0]      index_q;
  logic [oaids_pkg::WORD_W-1:0]     value_q;
  logic                             last_q;
  logic [oaids_pkg::CNT_W-1:0]      total_q;

  assign j_inc = {1'b0, j_q} + (oaids_pkg::CNT_W+1)'(1);

  // start index per operation
  always_comb begin
    j_d = j_q;
    if (cmd_i.load) begin
      case (oaids_pkg::func_e'(func_i))
        oaids_pkg::FUNC_INSERT: j_d = count_q;
        oaids_pkg::FUNC_DELETE: j_d = oaids_pkg::CNT_W'(position_i);
        default:                j_d = '0;
      endcase
    end else if (cmd_i.step) begin
      if (func_q == oaids_pkg::FUNC_INSERT) begin
        j_d = j_q - oaids_pkg::CNT_W'(1);
      end else begin
        j_d = oaids_pkg::CNT_W'(j_inc);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + oaids_pkg::CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - oaids_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    if (cmd_i.load) begin
      func_q <= oaids_pkg::func_e'(func_i);
      pos_q  <= position_i;
      item_q <= item_i;
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      index_q  <= cmd_i.emit_found ? oaids_pkg::IDX_W'(j_q) : '0;
      value_q  <= cmd_i.emit_data ? rdata : '0;
      last_q   <= cmd_i.emit_last;
      total_q  <= count_d;
    end
  end

  // insert moves j-1 up to j, delete moves j+1 down to j
  always_comb begin
    case (func_q)
      oaids_pkg::FUNC_INSERT: raddr = oaids_pkg::ADDR_W'(j_q - oaids_pkg::CNT_W'(1));
      oaids_pkg::FUNC_DELETE: raddr = oaids_pkg::ADDR_W'(j_inc);
      default:                raddr = oaids_pkg::ADDR_W'(j_q);
    endcase
  end

  assign we    = cmd_i.wr_shift | cmd_i.wr_item;
  assign waddr = cmd_i.wr_item ? oaids_pkg::ADDR_W'(pos_q) : oaids_pkg::ADDR_W'(j_q);
  assign wdata = cmd_i.wr_item ? item_q : rdata;

  oaids_ram #(
    .WIDTH(oaids_pkg::WORD_W),
    .DEPTH(oaids_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    sts_o.func    = func_q;
    sts_o.full    = (count_q == oaids_pkg::CNT_W'(oaids_pkg::DEPTH));
    sts_o.empty   = (count_q == '0);
    sts_o.match   = (rdata == item_q);
    sts_o.is_last = (j_inc == {1'b0, count_q});
    case (func_q)
      oaids_pkg::FUNC_INSERT: begin
        sts_o.bad_pos = ({1'b0, pos_q} > {1'b0, count_q});
        sts_o.more    = ({1'b0, j_q} > {1'b0, pos_q});
      end
      oaids_pkg::FUNC_DELETE: begin
        sts_o.bad_pos = ({1'b0, pos_q} >= {1'b0, count_q});
        sts_o.more    = (j_inc < {1'b0, count_q});
      end
      default: begin
        sts_o.bad_pos = 1'b0;
        sts_o.more    = (j_q < count_q);
      end
    endcase
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign found_index_o  = index_q;
  assign value_o        = value_q;
  assign last_o         = last_q;
  assign entry_total_o  = total_q;

endmodule

>>> hdl/oaids_ctrl.sv
module oaids_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  oaids_pkg::dp_sts_t sts_i,
  output oaids_pkg::dp_cmd_t cmd_o
);

  oaids_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oaids_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_status = oaids_pkg::ST_OK;
    cmd_o.emit_last   = 1'b1;
    case (state_q)
      oaids_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = oaids_pkg::S_DECIDE;
        end
      end
      // error checks are stable across the loop, so they are reevaluated harmlessly
      oaids_pkg::S_DECIDE: begin
        state_d = oaids_pkg::S_IDLE;
        case (sts_i.func)
          oaids_pkg::FUNC_INSERT: begin
            if (sts_i.full) begin
              cmd_o.emit = 1'b1;
              cmd_o.emit_status = oaids_pkg::ST_OVERFLOW;
            end else if (sts_i.bad_pos) begin
              cmd_o.emit = 1'b1;
              cmd_o.emit_status = oaids_pkg::ST_BADPOS;
            end else if (sts_i.more) begin
              state_d = oaids_pkg::S_READ;
            end else begin
              cmd_o.wr_item = 1'b1;
              cmd_o.cnt_inc = 1'b1;
              cmd_o.emit    = 1'b1;
            end
          end
          oaids_pkg::FUNC_DELETE: begin
            if (sts_i.bad_pos) begin
              cmd_o.emit = 1'b1;
              cmd_o.emit_status = oaids_pkg::ST_BADPOS;
            end else if (sts_i.more) begin
              state_d = oaids_pkg::S_READ;
            end else begin
              cmd_o.cnt_dec = 1'b1;
              cmd_o.emit    = 1'b1;
            end
          end
          oaids_pkg::FUNC_SEARCH: begin
            if (sts_i.more) begin
              state_d = oaids_pkg::S_READ;
            end else begin
              cmd_o.emit = 1'b1;
              cmd_o.emit_status = oaids_pkg::ST_NOTFOUND;
            end
          end
          default: begin
            if (sts_i.empty) begin
              cmd_o.emit = 1'b1;
              cmd_o.emit_status = oaids_pkg::ST_EMPTY;
            end else begin
              state_d = oaids_pkg::S_READ;
            end
          end
        endcase
      end
      oaids_pkg::S_READ: begin
        state_d = oaids_pkg::S_USE;
      end
      oaids_pkg::S_USE: begin
        case (sts_i.func)
          oaids_pkg::FUNC_SEARCH: begin
            if (sts_i.match) begin
              cmd_o.emit       = 1'b1;
              cmd_o.emit_found = 1'b1;
              state_d          = oaids_pkg::S_IDLE;
            end else begin
              cmd_o.step = 1'b1;
              state_d    = oaids_pkg::S_DECIDE;
            end
          end
          oaids_pkg::FUNC_DISPLAY: begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_data = 1'b1;
            cmd_o.emit_last = sts_i.is_last;
            cmd_o.step      = 1'b1;
            state_d = sts_i.is_last ? oaids_pkg::S_IDLE : oaids_pkg::S_READ;
          end
          default: begin
            cmd_o.wr_shift = 1'b1;
            cmd_o.step     = 1'b1;
            state_d        = oaids_pkg::S_DECIDE;
          end
        endcase
      end
      default: begin
        state_d = oaids_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != oaids_pkg::S_IDLE);

endmodule

>>> hdl/ordered_array_insert_delete_search.sv
// Sequence: error results, appends and last-entry deletes are settled in the decide state;
//   each entry shifted or searched past adds a pass through decide, memory read and use,
//   and display emits one entry per pass through memory read and use.
// Throughput: one transaction at a time; a new start is taken as the final result shows.
// Reset: rst_ni clears the entry count, controller state and result strobe; the element
//   memory is not cleared (entries are only read below the count). Results cannot be stalled.
module ordered_array_insert_delete_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [oaids_pkg::FUNC_W-1:0]         func_i,
  input  logic [oaids_pkg::POS_W-1:0]          position_i,
  input  logic signed [oaids_pkg::WORD_W-1:0]  item_i,
  output logic                                 result_valid_o,
  output logic [oaids_pkg::STATUS_W-1:0]       status_o,
  output logic [oaids_pkg::IDX_W-1:0]          found_index_o,
  output logic signed [oaids_pkg::WORD_W-1:0]  value_o,
  output logic                                 last_o,
  output logic [oaids_pkg::CNT_W-1:0]          entry_total_o
);

  // Control/status exchange between the sequencer and the datapath.
  oaids_pkg::dp_cmd_t cmd;
  oaids_pkg::dp_sts_t sts;

  // Sequencer: one pass through decide/read/use per entry moved or searched; display loops read/use.
  oaids_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: captured transaction, index walker, entry count, element memory
  // and the registered result outputs (one-cycle strobe).
  oaids_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (func_i),
    .position_i    (position_i),
    .item_i        (item_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .value_o       (value_o),
    .last_o        (last_o),
    .entry_total_o (entry_total_o)
  );

endmodule

>>> hdl/oaids_chk.sv
module oaids_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               result_valid_i,
  input logic [oaids_pkg::STATUS_W-1:0]     status_i,
  input logic                               last_i,
  input logic [oaids_pkg::CNT_W-1:0]        entry_total_i
);

  // an accepted transaction raises busy in the cycle after it is taken
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // a non-final display result means more results are still in flight
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !last_i |-> busy)
    else $error("block idle while a display is unfinished");

  // the final result frees the block
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && last_i |-> !busy)
    else $error("block still busy after final result");

  // error results are single, final results
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && (status_i != oaids_pkg::ST_OK) |-> last_i)
    else $error("error result not marked last");

  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && (status_i == oaids_pkg::ST_EMPTY) |-> (entry_total_i == '0))
    else $error("empty status with nonzero entry total");

endmodule

bind ordered_array_insert_delete_search oaids_chk u_oaids_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_i(result_valid_o),
  .status_i      (status_o),
  .last_i        (last_o),
  .entry_total_i (entry_total_o)
);

>>> bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oaids_pkg::*;

  // Generous bound: covers the worst insert/delete, which shifts 63 entries, a full
  // display of 64 entries and the sender gaps, over every generated item.
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int RAND_TOTAL  = 180;

  // One command to the list block
  typedef struct {
    func_e              func;
    logic [POS_W-1:0]   pos;
    logic signed [31:0] item;
    bit                 drain;   // hold off until every result is back
  } list_cmd_t;

  // One expected result transaction
  typedef struct {
    status_e            status;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] value;
    logic               is_last;
    logic [CNT_W-1:0]   total;
  } list_rsp_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     start          = 1'b0;
  logic                     busy;
  logic [FUNC_W-1:0]        func_i         = '0;
  logic [POS_W-1:0]         position_i     = '0;
  logic signed [WORD_W-1:0] item_i         = '0;
  logic                     result_valid_o;
  logic [STATUS_W-1:0]      status_o;
  logic [IDX_W-1:0]         found_index_o;
  logic signed [WORD_W-1:0] value_o;
  logic                     last_o;
  logic [CNT_W-1:0]         entry_total_o;

  ordered_array_insert_delete_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .position_i     (position_i),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_index_o  (found_index_o),
    .value_o        (value_o),
    .last_o         (last_o),
    .entry_total_o  (entry_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus and scoreboard storage
  list_cmd_t cmd_q[$];     // commands not yet taken by the block
  list_rsp_t rsp_q[$];     // results still owed by the block

  // Shadow copy of the list, advanced once per accepted transaction
  logic signed [31:0] shadow_mem [DEPTH];
  int unsigned        shadow_cnt = 0;

  int unsigned gen_cnt   = 0;   // list fill as seen while building stimulus
  int unsigned n_gen     = 0;
  int unsigned n_err     = 0;
  int unsigned n_rsp     = 0;
  int unsigned n_func [4] = '{0, 0, 0, 0};
  int unsigned n_status [5] = '{0, 0, 0, 0, 0};
  int unsigned peak_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // ---------------------------------------------------------------------
  // Predictor: apply one command to the shadow list, queue its results
  // ---------------------------------------------------------------------
  task automatic owe_rsp(status_e st, int unsigned idx, logic signed [31:0] val, bit lst);
    list_rsp_t r;
    r.status  = st;
    r.idx     = idx[IDX_W-1:0];
    r.value   = val;
    r.is_last = lst;
    r.total   = shadow_cnt[CNT_W-1:0];
    rsp_q.push_back(r);
  endtask

  task automatic apply_list_op(list_cmd_t c);
    int  j;
    bit  hit;
    n_func[c.func]++;
    case (c.func)
      FUNC_INSERT: begin
        // full check wins over the position check
        if (shadow_cnt >= DEPTH) begin
          owe_rsp(ST_OVERFLOW, 0, 0, 1'b1);
        end else if (c.pos > shadow_cnt) begin
          owe_rsp(ST_BADPOS, 0, 0, 1'b1);
        end else begin
          for (j = shadow_cnt; j > c.pos; j--) shadow_mem[j] = shadow_mem[j-1];
          shadow_mem[c.pos] = c.item;
          shadow_cnt++;
          owe_rsp(ST_OK, 0, 0, 1'b1);
        end
      end
      FUNC_DELETE: begin
        if (c.pos >= shadow_cnt) begin
          owe_rsp(ST_BADPOS, 0, 0, 1'b1);
        end else begin
          for (j = c.pos; j + 1 < shadow_cnt; j++) shadow_mem[j] = shadow_mem[j+1];
          shadow_cnt--;
          owe_rsp(ST_OK, 0, 0, 1'b1);
        end
      end
      FUNC_SEARCH: begin
        // first match wins
        hit = 1'b0;
        for (j = 0; j < shadow_cnt && !hit; j++) begin
          if (shadow_mem[j] == c.item) begin
            hit = 1'b1;
            owe_rsp(ST_OK, j, 0, 1'b1);
          end
        end
        if (!hit) owe_rsp(ST_NOTFOUND, 0, 0, 1'b1);
      end
      default: begin
        if (shadow_cnt == 0) begin
          owe_rsp(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          for (j = 0; j < shadow_cnt; j++)
            owe_rsp(ST_OK, 0, shadow_mem[j], j + 1 == shadow_cnt);
        end
      end
    endcase
    if (shadow_cnt > peak_cnt) peak_cnt = shadow_cnt;
  endtask

  // ---------------------------------------------------------------------
  // Driver: one command presented at a time from cmd_q, bursts and gaps
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    logic go;
    go = 1'b0;
    if (rst_ni) begin
      // transaction taken at this edge
      if (start && !busy) begin
        apply_list_op(cmd_q[0]);
        void'(cmd_q.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      if (start && busy) begin
        go = 1'b1;   // keep the same command up until taken
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() > 0) begin
        // drain point: wait for the block to deliver everything owed
        if (!(cmd_q[0].drain && rsp_q.size() != 0)) begin
          go = 1'b1;
          cmd_q[0].drain = 1'b0;
          func_i     <= cmd_q[0].func;
          position_i <= cmd_q[0].pos;
          item_i     <= cmd_q[0].item;
        end
      end
      start <= go;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobed result against the oldest owed result
  // ---------------------------------------------------------------------
  task automatic cmp_field(string nm, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $realtime, nm, want, got);
    end
  endtask

  always @(posedge clk_i) begin : mon_proc
    list_rsp_t r;
    if (rst_ni && result_valid_o) begin
      if (rsp_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result, expected none, actual status %0d value 'h%0h",
                 $realtime, status_o, value_o);
      end else begin
        r = rsp_q.pop_front();
        n_rsp++;
        if (r.status <= ST_EMPTY) n_status[r.status]++;
        cmp_field("status",      32'(r.status),  32'(status_o));
        cmp_field("found_index", 32'(r.idx),     32'(found_index_o));
        cmp_field("value",       r.value,        value_o);
        cmp_field("last",        32'(r.is_last), 32'(last_o));
        cmp_field("entry_total", 32'(r.total),   32'(entry_total_o));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  task automatic add_cmd(func_e f, int unsigned p, logic [31:0] it, bit drain);
    list_cmd_t c;
    c.func  = f;
    c.pos   = p[POS_W-1:0];
    c.item  = it;
    c.drain = drain;
    cmd_q.push_back(c);
    n_gen++;
    if (f == FUNC_INSERT && gen_cnt < DEPTH && p <= gen_cnt) gen_cnt++;
    else if (f == FUNC_DELETE && p < gen_cnt) gen_cnt--;
  endtask

  // small pool makes search hits and duplicates common
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0:       w = 32'h0000_0000;
      1:       w = 32'hFFFF_FFFF;
      2:       w = 32'h7FFF_FFFF;
      3:       w = 32'h8000_0000;
      4, 5:    w = $urandom_range(1, 6);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // weights in percent: insert, delete, search; display takes the rest
  task automatic add_random(int unsigned w_ins, int unsigned w_del, int unsigned w_srch);
    int unsigned r;
    int unsigned p;
    r = $urandom_range(0, 99);
    if (r < w_ins) begin
      p = ($urandom_range(0, 99) < 85) ? $urandom_range(0, gen_cnt) : $urandom_range(0, 127);
      add_cmd(FUNC_INSERT, p, pick_word(), $urandom_range(0, 39) == 0);
    end else if (r < w_ins + w_del) begin
      p = (gen_cnt > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, gen_cnt - 1)
                                                       : $urandom_range(0, 127);
      add_cmd(FUNC_DELETE, p, $urandom, 1'b0);
    end else if (r < w_ins + w_del + w_srch) begin
      add_cmd(FUNC_SEARCH, $urandom_range(0, 127), pick_word(), 1'b0);
    end else begin
      add_cmd(FUNC_DISPLAY, $urandom_range(0, 127), $urandom, 1'b0);
    end
  endtask

  initial begin : main_proc
    int unsigned dir_n;

    // --- directed: empty list cases, edges, duplicates, all ops ---
    add_cmd(FUNC_DISPLAY, 0,   32'h0,         1'b0);  // empty display
    add_cmd(FUNC_DELETE,  0,   32'h0,         1'b0);  // delete on empty
    add_cmd(FUNC_SEARCH,  0,   32'h0,         1'b0);  // search on empty
    add_cmd(FUNC_INSERT,  1,   32'h1,         1'b0);  // past end
    add_cmd(FUNC_INSERT,  0,   32'h7FFF_FFFF, 1'b0);
    add_cmd(FUNC_INSERT,  1,   32'h8000_0000, 1'b0);  // append
    add_cmd(FUNC_INSERT,  0,   32'h0000_0000, 1'b0);  // front
    add_cmd(FUNC_INSERT,  1,   32'hFFFF_FFFF, 1'b0);  // middle
    add_cmd(FUNC_INSERT,  5,   32'h1234_5678, 1'b0);  // one past end
    add_cmd(FUNC_INSERT,  127, 32'h5555_5555, 1'b0);  // max position
    add_cmd(FUNC_INSERT,  4,   32'hAAAA_AAAA, 1'b0);  // append at count
    add_cmd(FUNC_INSERT,  2,   32'hFFFF_FFFF, 1'b0);  // duplicate
    add_cmd(FUNC_SEARCH,  127, 32'hFFFF_FFFF, 1'b0);  // first of duplicates
    add_cmd(FUNC_SEARCH,  0,   32'h8000_0000, 1'b0);
    add_cmd(FUNC_SEARCH,  0,   32'h0001_2345, 1'b0);  // miss
    add_cmd(FUNC_DISPLAY, 0,   32'h0,         1'b0);
    add_cmd(FUNC_DELETE,  6,   32'h0,         1'b0);  // position == count
    add_cmd(FUNC_DELETE,  127, 32'hFFFF_FFFF, 1'b0);
    add_cmd(FUNC_DELETE,  1,   32'h0,         1'b0);  // middle
    add_cmd(FUNC_DELETE,  4,   32'h0,         1'b0);  // last entry
    add_cmd(FUNC_DELETE,  0,   32'h0,         1'b0);  // first entry
    add_cmd(FUNC_DISPLAY, 127, 32'h0,         1'b0);
    add_cmd(FUNC_SEARCH,  0,   32'h7FFF_FFFF, 1'b1);  // pause for full drain
    dir_n = n_gen;

    // --- random mix around a short list ---
    repeat (50) add_random(50, 15, 25);

    // --- fill to capacity, then the full-list corners ---
    add_cmd(FUNC_INSERT, $urandom_range(0, gen_cnt), pick_word(), 1'b1);
    while (gen_cnt < DEPTH) add_cmd(FUNC_INSERT, $urandom_range(0, gen_cnt), pick_word(), 1'b0);
    add_cmd(FUNC_INSERT,  0,         $urandom,      1'b0);  // overflow
    add_cmd(FUNC_INSERT,  127,       $urandom,      1'b0);  // overflow beats bad position
    add_cmd(FUNC_DISPLAY, 0,         32'h0,         1'b0);  // 64 results
    add_cmd(FUNC_SEARCH,  0,         pick_word(),   1'b0);
    add_cmd(FUNC_DELETE,  DEPTH,     32'h0,         1'b0);  // just past end
    add_cmd(FUNC_DELETE,  DEPTH - 1, 32'h0,         1'b0);
    add_cmd(FUNC_INSERT,  DEPTH - 1, 32'h8000_0000, 1'b0);  // append into last slot
    add_cmd(FUNC_DELETE,  0,         32'h0,         1'b0);  // longest shift down
    add_cmd(FUNC_INSERT,  0,         32'h7FFF_FFFF, 1'b0);  // longest shift up

    // --- shrink back down, then a final mix ---
    while (gen_cnt > 8) add_random(5, 85, 5);
    while (n_gen - dir_n < RAND_TOTAL || gen_cnt > 0) begin
      if (n_gen - dir_n < RAND_TOTAL) add_random(40, 25, 20);
      else add_cmd(FUNC_DELETE, $urandom_range(0, gen_cnt - 1), $urandom, 1'b0);
    end
    add_cmd(FUNC_DISPLAY, 0, 32'h0, 1'b0);  // empty again at the very end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || rsp_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions (%0d insert, %0d delete, %0d search, %0d display), peak fill %0d/%0d.",
             n_gen, n_func[FUNC_INSERT], n_func[FUNC_DELETE], n_func[FUNC_SEARCH],
             n_func[FUNC_DISPLAY], peak_cnt, DEPTH);
    $display("Checked %0d results: ok %0d, overflow %0d, bad position %0d, not found %0d, empty %0d.",
             n_rsp, n_status[ST_OK], n_status[ST_OVERFLOW], n_status[ST_BADPOS],
             n_status[ST_NOTFOUND], n_status[ST_EMPTY]);
    if (n_err == 0 && rsp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog_proc
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles, %0d commands and %0d results outstanding",
             $realtime, cycle_cnt, cmd_q.size(), rsp_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
